/* src/i2cph_pkg.sv */
package i2cph_pkg;

    localparam int RX_DEPTH    = 64;
    localparam int TX_DEPTH    = 64;
    localparam int MAX_RESULTS = 64;

    localparam int RX_AW  = $clog2(RX_DEPTH);
    localparam int TX_AW  = $clog2(TX_DEPTH);
    localparam int RX_CW  = $clog2(RX_DEPTH + 3);
    localparam int TX_CW  = $clog2(TX_DEPTH + 1);
    localparam int JOB_W  = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W  = $clog2(MAX_RESULTS);

    localparam logic [7:0] FLAG_PARSER_RESET = 8'h10;
    localparam logic [7:0] FLAG_QUERY_STATUS = 8'h11;
    localparam logic [7:0] FLAG_RAW_DATA     = 8'h55;
    localparam logic [7:0] TERMINATOR_RESET  = 8'h04;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_APPEND = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_MASTER  = 2'd1,
        KIND_RESET   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        SRC_RESET  = 2'd0,
        SRC_HEADER = 2'd1,
        SRC_RX     = 2'd2,
        SRC_TX     = 2'd3
    } src_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_ISSUE = 1'b1
    } state_t;

    typedef struct packed {
        logic accept;
        logic issue;
    } ctrl_cmd_t;

    typedef struct packed {
        logic job_nonempty;
        logic can_issue;
        logic issue_last;
    } ctrl_status_t;

endpackage

/* src/i2cph_ctrl.sv */
module i2cph_ctrl
    import i2cph_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.job_nonempty)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = status.can_issue;
                if (status.can_issue && status.issue_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/i2cph_datapath.sv */
module i2cph_datapath
    import i2cph_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    input  logic [15:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status
);

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    logic [7:0]       term_reg;
    logic [RX_CW-1:0] rx_count_reg, rx_count_next;
    logic [7:0]       rx_length_reg, rx_length_next;
    logic [7:0]       rx_flag_reg, rx_flag_next;
    logic [TX_CW-1:0] tx_count_reg, tx_count_next;
    logic [1:0]       tx_status_reg, tx_status_next;
    logic             lsp_reg, lsp_next;
    logic [TX_CW-1:0] sent_len_reg, sent_len_next;

    src_t             job_src_reg, job_src_next;
    logic [JOB_W-1:0] job_len_reg, job_len_next;
    logic [IDX_W-1:0] idx_reg;

    logic             b_valid_reg;
    logic [1:0]       b_kind_reg;
    logic             b_last_reg;
    logic             b_mem_reg;
    logic             b_from_rx_reg;
    logic [7:0]       b_const_reg;
    logic [7:0]       rx_rd_reg;
    logic [7:0]       tx_rd_reg;

    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic [1:0]       out_kind_reg;
    logic             out_last_reg;

    logic [7:0]       in_byte;
    logic             in_busy;
    logic [7:0]       length_cur;
    logic [7:0]       flag_cur;
    logic [RX_CW-1:0] rx_inc;
    logic             pkt_end;
    logic [8:0]       pay9;
    logic [8:0]       got9;
    logic             rx_wr;
    logic             tx_wr;
    logic             advance;
    logic             b_free;
    logic [7:0]       b_value;
    logic [1:0]       iss_kind;
    logic [7:0]       iss_const;
    logic             iss_last;

    assign in_byte = s_tdata[7:0];
    assign in_busy = s_tdata[8];

    assign length_cur = (rx_count_reg == '0) ? in_byte : rx_length_reg;
    assign flag_cur   = (rx_count_reg == RX_CW'(1)) ? in_byte : rx_flag_reg;
    assign rx_inc     = rx_count_reg + RX_CW'(1);

    always_comb
    begin
        pkt_end = (9'(rx_inc) == (9'(length_cur) + 9'd2))
               || (9'(rx_inc) >= 9'(RX_DEPTH + 2))
               || (in_byte == term_reg);
        pay9 = (9'(rx_inc) >= 9'd2) ? (9'(rx_inc) - 9'd2) : 9'd0;
        got9 = pay9;
        if (got9 > 9'(length_cur))
        begin
            got9 = 9'(length_cur);
        end
        if (got9 > 9'(MAX_RESULTS))
        begin
            got9 = 9'(MAX_RESULTS);
        end
    end

    always_comb
    begin
        rx_count_next  = rx_count_reg;
        rx_length_next = rx_length_reg;
        rx_flag_next   = rx_flag_reg;
        tx_count_next  = tx_count_reg;
        tx_status_next = tx_status_reg;
        lsp_next       = lsp_reg;
        sent_len_next  = sent_len_reg;
        job_src_next   = job_src_reg;
        job_len_next   = '0;
        rx_wr          = 1'b0;
        tx_wr          = 1'b0;
        unique case (s_tuser)
            CMD_WRITE:
            begin
                rx_length_next = length_cur;
                rx_flag_next   = flag_cur;
                rx_wr = (rx_count_reg >= RX_CW'(2))
                     && (9'(rx_count_reg) - 9'd2 < 9'(RX_DEPTH));
                rx_count_next = rx_inc;
                if (pkt_end)
                begin
                    rx_count_next = '0;
                    unique case (flag_cur)
                        FLAG_PARSER_RESET:
                        begin
                            job_src_next  = SRC_RESET;
                            job_len_next  = JOB_W'(1);
                            tx_count_next = '0;
                            lsp_next      = 1'b0;
                        end
                        FLAG_QUERY_STATUS:
                        begin
                            sent_len_next  = '0;
                            tx_status_next = {tx_count_reg != '0, in_busy};
                        end
                        FLAG_RAW_DATA:
                        begin
                            job_src_next = SRC_RX;
                            job_len_next = JOB_W'(got9);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            CMD_READ:
            begin
                if (lsp_reg)
                begin
                    job_src_next  = SRC_TX;
                    job_len_next  = JOB_W'(sent_len_reg);
                    tx_count_next = '0;
                    lsp_next      = 1'b0;
                    sent_len_next = '0;
                end
                else
                begin
                    job_src_next  = SRC_HEADER;
                    job_len_next  = JOB_W'(2);
                    sent_len_next = tx_count_reg;
                    lsp_next      = (tx_count_reg != '0);
                end
            end
            CMD_APPEND:
            begin
                if (tx_count_reg < TX_CW'(TX_DEPTH))
                begin
                    tx_wr         = 1'b1;
                    tx_count_next = tx_count_reg + TX_CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign advance = !out_valid_reg || m_tready;
    assign b_free  = !b_valid_reg || advance;
    assign b_value = b_mem_reg ? (b_from_rx_reg ? rx_rd_reg : tx_rd_reg) : b_const_reg;

    assign iss_last = ((JOB_W'(idx_reg) + JOB_W'(1)) == job_len_reg);

    always_comb
    begin
        iss_kind  = KIND_MASTER;
        iss_const = '0;
        unique case (job_src_reg)
            SRC_RESET:
            begin
                iss_kind = KIND_RESET;
            end
            SRC_HEADER:
            begin
                iss_const = (idx_reg == '0) ? 8'(tx_count_reg) : 8'(tx_status_reg);
            end
            SRC_RX:
            begin
                iss_kind = KIND_PAYLOAD;
            end
            SRC_TX:
            begin
                iss_kind = KIND_MASTER;
            end
            default:
            begin
            end
        endcase
    end

    assign status.job_nonempty = (job_len_next != '0);
    assign status.can_issue    = b_free;
    assign status.issue_last   = iss_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg      <= TERMINATOR_RESET;
            rx_count_reg  <= '0;
            rx_length_reg <= '0;
            rx_flag_reg   <= '0;
            tx_count_reg  <= '0;
            tx_status_reg <= '0;
            lsp_reg       <= 1'b0;
            sent_len_reg  <= '0;
            job_src_reg   <= SRC_RESET;
            job_len_reg   <= '0;
            idx_reg       <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                term_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                rx_count_reg  <= rx_count_next;
                rx_length_reg <= rx_length_next;
                rx_flag_reg   <= rx_flag_next;
                tx_count_reg  <= tx_count_next;
                tx_status_reg <= tx_status_next;
                lsp_reg       <= lsp_next;
                sent_len_reg  <= sent_len_next;
                job_src_reg   <= job_src_next;
                job_len_reg   <= job_len_next;
                idx_reg       <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (b_free)
            begin
                b_valid_reg <= cmd.issue;
            end
            if (advance)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_free && cmd.issue)
        begin
            b_kind_reg    <= iss_kind;
            b_last_reg    <= iss_last;
            b_mem_reg     <= (job_src_reg == SRC_RX) || (job_src_reg == SRC_TX);
            b_from_rx_reg <= (job_src_reg == SRC_RX);
            b_const_reg   <= iss_const;
        end
        if (advance && b_valid_reg)
        begin
            out_data_reg <= b_value;
            out_kind_reg <= b_kind_reg;
            out_last_reg <= b_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && rx_wr)
        begin
            rx_mem[RX_AW'(rx_count_reg - RX_CW'(2))] <= in_byte;
        end
        if (b_free && cmd.issue && (job_src_reg == SRC_RX))
        begin
            rx_rd_reg <= rx_mem[RX_AW'(idx_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && tx_wr)
        begin
            tx_mem[TX_AW'(tx_count_reg)] <= in_byte;
        end
        if (b_free && cmd.issue && (job_src_reg == SRC_TX))
        begin
            tx_rd_reg <= tx_mem[TX_AW'(idx_reg)];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* src/i2c_slave_packet_handler.sv */
// Channel  | Direction | Ports                          | Contents
// s        | in        | s_tvalid s_tready s_tdata s_tuser | command, data byte, parser busy
// m        | out       | m_tvalid m_tready m_tdata m_tuser m_tlast | result byte and kind
// cfg      | in        | cfg_wr_en cfg_wr_data          | terminator byte
//
// A request that yields no result leaves the block ready again at once.
// A request yielding N results issues one per cycle unless the output stalls, each from
// the receive or response memory or a constant, plus two register stages to the output.
// Reset clears all counters and flags and sets the terminator to 0x04.
// A stalled output stops issuing; a new request is taken once issuing is done.
module i2c_slave_packet_handler
    import i2cph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte [7:0], parser_busy [8], zero fill
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // value
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    i2cph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    i2cph_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
    import i2cph_pkg::*;
;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 200;

    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } reply_t;

    class engine_image;
        logic [7:0]  terminator;
        int unsigned rx_count;
        logic [7:0]  rx_length;
        logic [7:0]  rx_flag;
        logic [7:0]  rx_bytes[RX_DEPTH];
        int unsigned tx_count;
        logic [1:0]  tx_status;
        logic [7:0]  tx_bytes[TX_DEPTH];
        bit          reply_pending;
        int unsigned sent_length;
        reply_t      batch[$];
        reply_t      owed[$];
        int          mismatches;
        int          checked;
        int          taken;

        function new();
            terminator    = TERMINATOR_RESET;
            rx_count      = 0;
            rx_length     = 8'h00;
            rx_flag       = 8'h00;
            tx_count      = 0;
            tx_status     = 2'b00;
            reply_pending = 1'b0;
            sent_length   = 0;
            mismatches    = 0;
            checked       = 0;
            taken         = 0;
        endfunction

        function void owe(kind_t kind, logic [7:0] value);
            if (batch.size() < MAX_RESULTS)
                batch.push_back('{kind, value, 1'b0});
        endfunction

        function void finish_packet(logic busy);
            int unsigned got;
            case (rx_flag)
                FLAG_PARSER_RESET:
                begin
                    owe(KIND_RESET, 8'h00);
                    tx_count      = 0;
                    reply_pending = 1'b0;
                end
                FLAG_QUERY_STATUS:
                begin
                    sent_length = 0;
                    tx_status   = {tx_count != 0, busy};
                end
                FLAG_RAW_DATA:
                begin
                    got = (rx_count >= 2) ? rx_count - 2 : 0;
                    if (got > rx_length)
                        got = rx_length;
                    if (got > RX_DEPTH)
                        got = RX_DEPTH;
                    for (int i = 0; i < got; i++)
                        owe(KIND_PAYLOAD, rx_bytes[i]);
                end
                default:
                    ;
            endcase
            rx_count = 0;
        endfunction

        function void absorb_request(logic [1:0] cmd, logic [7:0] data, logic busy);
            reply_t tail;
            batch.delete();
            taken++;
            case (cmd)
                CMD_WRITE:
                begin
                    if (rx_count == 0)
                        rx_length = data;
                    else if (rx_count == 1)
                        rx_flag = data;
                    else if (rx_count - 2 < RX_DEPTH)
                        rx_bytes[rx_count - 2] = data;
                    rx_count++;
                    if (rx_count == rx_length + 2 || rx_count >= RX_DEPTH + 2
                            || data == terminator)
                        finish_packet(busy);
                end
                CMD_READ:
                begin
                    if (reply_pending)
                    begin
                        for (int i = 0; i < sent_length && i < TX_DEPTH; i++)
                            owe(KIND_MASTER, tx_bytes[i]);
                        tx_count      = 0;
                        reply_pending = 1'b0;
                        sent_length   = 0;
                    end
                    else
                    begin
                        sent_length = tx_count;
                        owe(KIND_MASTER, 8'(tx_count));
                        owe(KIND_MASTER, {6'b0, tx_status});
                        if (tx_count > 0)
                            reply_pending = 1'b1;
                        else
                        begin
                            tx_count      = 0;
                            reply_pending = 1'b0;
                        end
                    end
                end
                CMD_APPEND:
                begin
                    if (tx_count < TX_DEPTH)
                    begin
                        tx_bytes[tx_count] = data;
                        tx_count++;
                    end
                end
                default:
                    ;
            endcase
            if (batch.size() > 0)
            begin
                tail      = batch.pop_back();
                tail.last = 1'b1;
                batch.push_back(tail);
                foreach (batch[i])
                    owed.push_back(batch[i]);
            end
        endfunction

        function void compare_output(logic [1:0] kind, logic [7:0] value, logic last);
            reply_t want;
            if (owed.size() == 0)
            begin
                mismatches++;
                $error("unexpected result: kind %0d value 0x%02h last %0b", kind, value, last);
                return;
            end
            want = owed.pop_front();
            checked++;
            if (kind !== want.kind)
            begin
                mismatches++;
                $error("kind: expected %0d, actual %0d", want.kind, kind);
            end
            if (value !== want.value)
            begin
                mismatches++;
                $error("value: expected 0x%02h, actual 0x%02h", want.value, value);
            end
            if (last !== want.last)
            begin
                mismatches++;
                $error("last: expected %0b, actual %0b", want.last, last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic [1:0]  s_tuser = 2'b00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic        hold_token = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    logic [9:0]  stall_phase = 10'd0;
    int          burst_left = 0;
    int          offered = 0;
    int          settings = 0;

    engine_image board = new();

    i2c_slave_packet_handler u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            stall_phase <= stall_phase + 10'd1;
            case (stall_phase[9:8])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_tready <= (stall_phase[1:0] != 2'd3);
                default: m_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.compare_output(m_tuser, m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                board.absorb_request(s_tuser, s_tdata[7:0], s_tdata[8]);
        end
    end

    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic offer(logic [1:0] cmd, logic [7:0] data, logic busy);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, busy, data};
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd != CMD_UNUSED)
            offered++;
        pace();
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_terminator(logic [7:0] code);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= code;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.terminator = code;
        settings++;
    endtask

    task automatic random_packet();
        int unsigned len;
        int unsigned body;
        int unsigned sel;
        logic [7:0]  flag;
        logic [7:0]  b;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            len = $urandom_range(0, 8);
        else if (sel < 95)
            len = $urandom_range(9, 63);
        else
            len = $urandom_range(64, 255);
        sel = $urandom_range(0, 99);
        if (sel < 35)
            flag = FLAG_RAW_DATA;
        else if (sel < 55)
            flag = FLAG_QUERY_STATUS;
        else if (sel < 70)
            flag = FLAG_PARSER_RESET;
        else
            flag = 8'($urandom_range(0, 255));
        body = (len > RX_DEPTH) ? RX_DEPTH : len;
        if ($urandom_range(0, 5) == 0)
            body = $urandom_range(0, body);
        offer(CMD_WRITE, len[7:0], 1'($urandom_range(0, 1)));
        offer(CMD_WRITE, flag, 1'($urandom_range(0, 1)));
        for (int i = 0; i < body; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 19) == 0)
                b = board.terminator;
            offer(CMD_WRITE, b, 1'($urandom_range(0, 1)));
        end
        if (body < len && len <= RX_DEPTH && $urandom_range(0, 1) == 0)
            offer(CMD_WRITE, board.terminator, 1'($urandom_range(0, 1)));
    endtask

    task automatic random_phase(int quota);
        int sel;
        int n;
        int stop;
        stop = offered + quota;
        while (offered < stop)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                random_packet();
            else if (sel < 60)
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
                repeat (n) offer(CMD_APPEND, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
            end
            else if (sel < 80)
            begin
                offer(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                offer(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else if (sel < 88)
                offer(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                offer(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [7:0] codes[5];
        codes = '{8'h00, 8'hFF, FLAG_RAW_DATA, 8'h00, TERMINATOR_RESET};
        codes[3] = 8'($urandom_range(0, 255));
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(CMD_READ, 8'h00, 1'b0);
        offer(CMD_APPEND, 8'h00, 1'b0);
        offer(CMD_APPEND, 8'hFF, 1'b1);
        offer(CMD_WRITE, 8'h00, 1'b0);
        offer(CMD_WRITE, FLAG_QUERY_STATUS, 1'b1);
        offer(CMD_READ, 8'hFF, 1'b0);
        offer(CMD_READ, 8'h00, 1'b1);
        offer(CMD_WRITE, 8'd2, 1'b0);
        offer(CMD_WRITE, FLAG_RAW_DATA, 1'b0);
        offer(CMD_WRITE, 8'hFF, 1'b1);
        offer(CMD_WRITE, 8'h00, 1'b0);
        offer(CMD_WRITE, 8'd3, 1'b0);
        offer(CMD_WRITE, FLAG_RAW_DATA, 1'b0);
        offer(CMD_WRITE, 8'h7E, 1'b0);
        offer(CMD_WRITE, TERMINATOR_RESET, 1'b0);
        offer(CMD_WRITE, TERMINATOR_RESET, 1'b0);
        offer(CMD_WRITE, 8'd5, 1'b0);
        offer(CMD_WRITE, TERMINATOR_RESET, 1'b1);
        offer(CMD_WRITE, 8'd1, 1'b0);
        offer(CMD_WRITE, 8'h33, 1'b0);
        offer(CMD_WRITE, 8'h99, 1'b0);
        offer(CMD_APPEND, 8'hA5, 1'b0);
        offer(CMD_WRITE, 8'h00, 1'b1);
        offer(CMD_WRITE, FLAG_PARSER_RESET, 1'b0);
        offer(CMD_READ, 8'h00, 1'b0);
        offer(CMD_UNUSED, 8'hFF, 1'b1);

        // The output is held off while a long packet, a full response buffer and
        // its readout are offered, so the block backs up and stalls its input.
        drain_results();
        hold_token <= ~hold_token;
        offer(CMD_WRITE, 8'd30, 1'b0);
        offer(CMD_WRITE, FLAG_RAW_DATA, 1'b0);
        repeat (30) offer(CMD_WRITE, 8'($urandom_range(5, 255)), 1'($urandom_range(0, 1)));
        repeat (66) offer(CMD_APPEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        offer(CMD_READ, 8'h00, 1'b0);
        offer(CMD_READ, 8'h00, 1'b0);

        foreach (codes[i])
        begin
            set_terminator(codes[i]);
            random_phase(45);
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (board.owed.size() != 0)
        begin
            board.mismatches++;
            $error("%0d expected results never arrived", board.owed.size());
        end
        $display("Covered %0d requests and %0d checked results over %0d terminator settings,",
                 board.taken, board.checked, settings);
        $display("including a long output hold-off and full receive and response buffers.");
        if (board.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
